// ===== sv/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants of the min priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;
  localparam int CAPACITY_DEF    = 64;
  localparam int VERTEX_BITS_DEF = 10;
  localparam int WEIGHT_BITS     = 40;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic scan_clr;  // clear scan index, hit flag, best
    logic rd;        // issue read at scan index
    logic eval;      // evaluate read data (previous address)
    logic ins_wr;    // write request at count
    logic mv_rd;     // read last entry
    logic mv_wr;     // write last entry into best slot
    logic cnt_inc;
    logic cnt_dec;
    logic res_set;   // present result
    logic [1:0] res_status;
    logic res_data;  // drive extracted pair
  } mpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       full;
    logic       scan_last;
    logic       hit;
  } mpq_sts_t;
endpackage

// ===== sv/min_priority_queue_with_update.sv =====
// ----------------------------------------------------------------------------
// min_priority_queue_with_update
// Min priority queue of (vertex, weight) pairs with insert, update, extract.
// ----------------------------------------------------------------------------
// Raise start while busy is low; a request is taken at the edge where both
// hold. An update or extract reads every stored entry once through the
// single read port. An update or extract on an empty queue, an insert into
// a full queue and the unused op code go straight to the result without
// touching the store. The result is on the out_ ports for one cycle with
// out_strobe high and cannot be stalled; busy is already low in that cycle,
// so the next request can be taken at its end. Ties go to the lowest vertex.
module min_priority_queue_with_update #(
  parameter int CAPACITY    = mpq_pkg::CAPACITY_DEF,
  parameter int VERTEX_BITS = mpq_pkg::VERTEX_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             in_op,
  input  logic [VERTEX_BITS-1:0]                 in_vertex_id,
  input  logic signed [mpq_pkg::WEIGHT_BITS-1:0] in_key_weight,
  output logic                                   out_strobe,
  output logic [VERTEX_BITS-1:0]                 out_vertex,
  output logic signed [mpq_pkg::WEIGHT_BITS-1:0] out_weight,
  output logic [1:0]                             out_status,
  output logic [$clog2(CAPACITY+1)-1:0]          out_occupancy
);
  import mpq_pkg::*;

  mpq_cmd_t cmd;
  mpq_sts_t sts;

  mpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .sts        (sts),
    .cmd        (cmd)
  );

  mpq_datapath #(.CAPACITY(CAPACITY), .VERTEX_BITS(VERTEX_BITS)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_vertex_id  (in_vertex_id),
    .in_key_weight (in_key_weight),
    .cmd           (cmd),
    .sts           (sts),
    .out_vertex    (out_vertex),
    .out_weight    (out_weight),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );
endmodule

// ===== sv/mpq_ram.sv =====
// ----------------------------------------------------------------------------
// mpq_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/mpq_datapath.sv =====
// ----------------------------------------------------------------------------
// mpq_datapath
// Entry store, count, scan index, best tracker and result registers.
// ----------------------------------------------------------------------------
module mpq_datapath #(
  parameter int CAPACITY    = mpq_pkg::CAPACITY_DEF,
  parameter int VERTEX_BITS = mpq_pkg::VERTEX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [1:0]                        in_op,
  input  logic [VERTEX_BITS-1:0]            in_vertex_id,
  input  logic signed [mpq_pkg::WEIGHT_BITS-1:0] in_key_weight,
  input  mpq_pkg::mpq_cmd_t                 cmd,
  output mpq_pkg::mpq_sts_t                 sts,
  output logic [VERTEX_BITS-1:0]            out_vertex,
  output logic signed [mpq_pkg::WEIGHT_BITS-1:0] out_weight,
  output logic [1:0]                        out_status,
  output logic [$clog2(CAPACITY+1)-1:0]     out_occupancy
);
  import mpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = VERTEX_BITS + WEIGHT_BITS;

  logic [1:0]               op_r;
  logic [VERTEX_BITS-1:0]   vtx_r;
  logic [WEIGHT_BITS-1:0]   wgt_r;
  logic [CW-1:0]            cnt_r;
  logic [CW-1:0]            idx_r;   // read address
  logic [AW-1:0]            eidx_r;  // address of data being evaluated
  logic                     hit_r;
  logic                     have_r;
  logic [AW-1:0]            best_idx_r;
  logic [VERTEX_BITS-1:0]   best_v_r;
  logic signed [WEIGHT_BITS-1:0] best_w_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [VERTEX_BITS-1:0]        rd_v;
  logic signed [WEIGHT_BITS-1:0] rd_w;
  logic [AW-1:0] last_idx;
  logic          upd_hit, better;

  assign rd_v     = rdata[EW-1:WEIGHT_BITS];
  assign rd_w     = rdata[WEIGHT_BITS-1:0];
  assign last_idx = AW'(cnt_r - CW'(1));
  assign upd_hit  = cmd.eval && (op_r == OP_UPDATE) && (rd_v == vtx_r);
  assign better   = !have_r || (rd_w < best_w_r) ||
                    ((rd_w == best_w_r) && (rd_v < best_v_r));

  always_comb begin
    we    = 1'b0;
    waddr = eidx_r;
    wdata = {vtx_r, wgt_r};
    raddr = cmd.mv_rd ? last_idx : idx_r[AW-1:0];
    if (cmd.ins_wr) begin
      we    = 1'b1;
      waddr = cnt_r[AW-1:0];
    end else if (cmd.mv_wr) begin
      we    = 1'b1;
      waddr = best_idx_r;
      wdata = rdata;
    end else if (upd_hit) begin
      we = 1'b1;
    end
  end

  mpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      out_status    <= ST_OK;
      out_vertex    <= '0;
      out_weight    <= '0;
      out_occupancy <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.res_set) begin
        out_status    <= cmd.res_status;
        out_vertex    <= cmd.res_data ? best_v_r : '0;
        out_weight    <= cmd.res_data ? best_w_r : '0;
        out_occupancy <= cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      vtx_r <= in_vertex_id;
      wgt_r <= in_key_weight;
    end
    if (cmd.scan_clr) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      have_r <= 1'b0;
    end else begin
      if (cmd.rd) begin
        idx_r  <= idx_r + CW'(1);
        eidx_r <= idx_r[AW-1:0];
      end
      if (upd_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.eval && (op_r == OP_EXTRACT) && better) begin
        have_r     <= 1'b1;
        best_idx_r <= eidx_r;
        best_v_r   <= rd_v;
        best_w_r   <= rd_w;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.empty     = (cnt_r == '0);
  assign sts.full      = (cnt_r == CW'(CAPACITY));
  assign sts.scan_last = (idx_r == cnt_r);
  assign sts.hit       = hit_r;
endmodule

// ===== sv/mpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for insert, update scan and extract scan with refill.
// ----------------------------------------------------------------------------
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_strobe,
  input  mpq_pkg::mpq_sts_t sts,
  output mpq_pkg::mpq_cmd_t cmd
);
  import mpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_DRAIN, S_MVRD, S_MVWR, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          OP_INSERT: begin
            cmd.res_set = 1'b1;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.ins_wr  = 1'b1;
              cmd.cnt_inc = 1'b1;
              cmd.res_set = 1'b0;
              state_nxt   = S_MVWR;
            end
          end
          OP_UPDATE, OP_EXTRACT: begin
            if (sts.empty) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = (sts.op == OP_UPDATE) ? ST_NOTFOUND : ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              cmd.rd    = 1'b1;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            cmd.res_set = 1'b1;
            state_nxt   = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.eval = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      S_DRAIN: begin
        if (sts.op == OP_UPDATE) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = sts.hit ? ST_OK : ST_NOTFOUND;
          state_nxt      = S_DONE;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MVRD;
        end
      end
      S_MVRD: begin
        cmd.mv_wr   = 1'b1;
        cmd.cnt_dec = 1'b1;
        state_nxt   = S_MVWR;
      end
      S_MVWR: begin
        cmd.res_set  = 1'b1;
        cmd.res_data = (sts.op == OP_EXTRACT);
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_strobe <= strobe_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

// ===== verif/min_priority_queue_with_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_with_update_tb
// Drives insert, update and extract requests into the queue with random gaps.
// A software copy of the queue predicts each result, and a scoreboard checks
// every strobed result against the predicted one.
// ----------------------------------------------------------------------------
module min_priority_queue_with_update_tb;
  import mpq_pkg::*;

  localparam int CAP   = 64;
  localparam int VB    = 10;
  localparam int WB    = WEIGHT_BITS;
  localparam int LIMIT = 20000;

  typedef struct packed {
    logic [VB-1:0]        vertex;
    logic signed [WB-1:0] weight;
    logic [1:0]           status;
    logic [6:0]           occupancy;
  } pq_result_t;

  class pq_scoreboard;
    logic [VB-1:0]        qv[CAP];
    logic signed [WB-1:0] qw[CAP];
    int                   count;
    pq_result_t           pending[$];
    int                   errors;

    function void note_request(logic [1:0] op, logic [VB-1:0] v,
                               logic signed [WB-1:0] w);
      pq_result_t r;
      int best;
      bit hit;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (count >= CAP) begin
            r.status = ST_FULL;
          end else begin
            qv[count] = v;
            qw[count] = w;
            count++;
          end
        end
        OP_UPDATE: begin
          hit = 0;
          for (int i = 0; i < count; i++) begin
            if (qv[i] == v) begin
              qw[i] = w;
              hit = 1;
            end
          end
          if (!hit) r.status = ST_NOTFOUND;
        end
        OP_EXTRACT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            best = 0;
            for (int i = 1; i < count; i++) begin
              if (qw[i] < qw[best] || (qw[i] == qw[best] && qv[i] < qv[best])) best = i;
            end
            r.vertex = qv[best];
            r.weight = qw[best];
            qv[best] = qv[count-1];
            qw[best] = qw[count-1];
            count--;
          end
        end
        default: ;
      endcase
      r.occupancy = 7'(count);
      pending.push_back(r);
    endfunction

    function void check_result(pq_result_t a);
      pq_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result vertex=%0d status=%0d", a.vertex, a.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.vertex !== e.vertex) begin
        $error("out_vertex: expected %0d actual %0d", e.vertex, a.vertex);
        errors++;
      end
      if (a.weight !== e.weight) begin
        $error("out_weight: expected %0d actual %0d", e.weight, a.weight);
        errors++;
      end
      if (a.status !== e.status) begin
        $error("out_status: expected %0d actual %0d", e.status, a.status);
        errors++;
      end
      if (a.occupancy !== e.occupancy) begin
        $error("out_occupancy: expected %0d actual %0d", e.occupancy, a.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_op;
  logic [VB-1:0]        in_vertex_id;
  logic signed [WB-1:0] in_key_weight;
  logic                 out_strobe;
  logic [VB-1:0]        out_vertex;
  logic signed [WB-1:0] out_weight;
  logic [1:0]           out_status;
  logic [6:0]           out_occupancy;

  pq_scoreboard sb;
  int           idle_cycles;
  bit           timed_out;
  logic [VB-1:0] recent[$];

  min_priority_queue_with_update #(.CAPACITY(CAP), .VERTEX_BITS(VB)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_vertex_id(in_vertex_id), .in_key_weight(in_key_weight),
    .out_strobe(out_strobe), .out_vertex(out_vertex), .out_weight(out_weight),
    .out_status(out_status), .out_occupancy(out_occupancy)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result({out_vertex, out_weight, out_status, out_occupancy});
    end
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > LIMIT && !timed_out) begin
      timed_out = 1;
      $display("min_priority_queue_with_update_tb NOT OK");
      $finish;
    end
  end

  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      9:          n = $urandom_range(20, 120);
      default:    n = $urandom_range(1, 4);
    endcase
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(logic [1:0] op, logic [VB-1:0] v, logic signed [WB-1:0] w);
    in_op         <= op;
    in_vertex_id  <= v;
    in_key_weight <= w;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(op, v, w);
    if (op == OP_INSERT) recent.push_back(v);
    if (recent.size() > 32) void'(recent.pop_front());
    start <= 1'b0;
    @(posedge clk);
    idle_gap();
  endtask

  function automatic logic signed [WB-1:0] rand_weight();
    logic signed [WB-1:0] w;
    w = WB'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: w = {1'b0, {(WB-1){1'b1}}};
      1: w = {1'b1, {(WB-1){1'b0}}};
      2: w = WB'($signed($urandom_range(0, 15)) - 8);
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [VB-1:0] rand_vertex();
    if (recent.size() > 0 && $urandom_range(0, 2) != 0)
      return recent[$urandom_range(0, recent.size() - 1)];
    return VB'($urandom_range(0, 1023));
  endfunction

  initial begin
    int k;
    logic [1:0] op;
    sb = new();
    sb.count = 0;
    sb.errors = 0;
    idle_cycles = 0;
    timed_out = 0;
    rst_n = 0;
    start = 0;
    in_op = OP_INSERT;
    in_vertex_id = '0;
    in_key_weight = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty extract, extremes, ties, updates, unused op
    send_request(OP_EXTRACT, 10'd0, '0);
    send_request(OP_UPDATE, 10'd5, '0);
    send_request(OP_INSERT, 10'd1023, {1'b0, {(WB-1){1'b1}}});
    send_request(OP_INSERT, 10'd0, {1'b1, {(WB-1){1'b0}}});
    send_request(OP_INSERT, 10'd7, 40'sd256);
    send_request(OP_INSERT, 10'd3, 40'sd256);
    send_request(OP_INSERT, 10'd7, -40'sd1);
    send_request(OP_UPDATE, 10'd7, 40'sd256);
    send_request(OP_NONE, 10'h3FF, -40'sd1);
    send_request(OP_UPDATE, 10'd999, 40'sd9);
    repeat (6) send_request(OP_EXTRACT, 10'd0, '0);
    for (k = 0; k < CAP + 2; k++) send_request(OP_INSERT, k[VB-1:0], 40'sd5);
    send_request(OP_UPDATE, 10'd63, -40'sd5);
    repeat (CAP + 1) send_request(OP_EXTRACT, 10'd0, '0);

    for (k = 0; k < 750; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: op = OP_INSERT;
        8, 9, 10, 11:           op = OP_UPDATE;
        19:                     op = OP_NONE;
        default:                op = OP_EXTRACT;
      endcase
      if ((k / 150) % 2 == 1 && op == OP_EXTRACT && $urandom_range(0, 1)) op = OP_INSERT;
      send_request(op, rand_vertex(), rand_weight());
    end

    k = 0;
    while (sb.pending.size() != 0 && k < LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("min_priority_queue_with_update_tb OK");
    end else begin
      $display("min_priority_queue_with_update_tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/mpq_pkg.sv
sv/mpq_ram.sv
sv/mpq_datapath.sv
sv/mpq_ctrl.sv
sv/min_priority_queue_with_update.sv
verif/min_priority_queue_with_update_tb.sv
